// File: rtl/core/tgarle_pkg.sv
// Shared types and constants of the TGA run-length pixel decoder.
// Used by every module under rtl/core; depends on nothing.

package tgarle_pkg;

  localparam int unsigned MAX_PIXELS  = 1048576;
  localparam int unsigned CNT_W       = 21;   // pixel_count / pixels_done width
  localparam int unsigned TOTAL_W     = 10;   // bytes of one run, up to 128 * 4
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_AW     = 2;
  localparam int unsigned OUT_TDATA_W = 72;   // 64 data + 4 count, padded to bytes

  localparam logic [7:0] RUN_HDR_MIN  = 8'd128;
  localparam logic [7:0] RUN_HDR_BIAS = 8'd127;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RAW    = 2'd1,
    PH_RUN    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CFG_BPP   = 2'd0,
    CFG_COUNT = 2'd1,
    CFG_RLE   = 2'd2
  } cfg_reg_t;

  // One entry of the front-to-back queue: a single result, or a run to expand.
  typedef struct packed {
    logic               is_run;
    logic               one_byte;   // single result carries data[7:0]
    logic [31:0]        data;       // literal byte or run color
    logic [TOTAL_W-1:0] total;      // run length in bytes, nonzero when is_run is set
    logic [2:0]         bpp;
    logic               status;
    logic               done;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// File: rtl/core/tgarle_cmd_fifo.sv
// Short command queue between the front (byte classifier) and the back (word emitter).
// Depends on tgarle_pkg.

module tgarle_cmd_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tgarle_pkg::cmd_t      push_cmd,
  input  logic                  pop,
  output tgarle_pkg::cmd_t      head,
  output tgarle_pkg::fifo_stat_t stat
);

  tgarle_pkg::cmd_t                   mem_r [tgarle_pkg::FIFO_DEPTH];
  logic [tgarle_pkg::FIFO_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [tgarle_pkg::FIFO_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [tgarle_pkg::FIFO_AW:0]       count_r, count_nxt;
  logic                               do_push, do_pop;

  assign stat.full  = (count_r == (tgarle_pkg::FIFO_AW+1)'(tgarle_pkg::FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // the front must hold off input while the queue is full
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full))
    else $error("command pushed into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (tgarle_pkg::FIFO_AW+1)'(tgarle_pkg::FIFO_DEPTH))
    else $error("queue count out of range");

endmodule

// File: rtl/core/tgarle_front.sv
// Front end: configuration registers, packet parsing and pixel accounting.
// Turns each input byte into at most one queue command. Depends on tgarle_pkg.

module tgarle_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [20:0]            cfg_data,
  input  tgarle_pkg::fifo_stat_t fifo_stat,
  output logic                   push,
  output tgarle_pkg::cmd_t       push_cmd
);

  localparam int unsigned CW = tgarle_pkg::CNT_W;

  tgarle_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]         ppl_r, ppl_nxt;       // pixels left in packet
  logic [1:0]         bip_r, bip_nxt;       // byte within pixel
  logic [31:0]        color_r, color_nxt;
  logic [CW-1:0]      pd_r, pd_nxt;         // pixels done
  logic               fin_r, fin_nxt;
  logic               err_r, err_nxt;
  logic [2:0]         bpp_r, bpp_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               rle_r, rle_nxt;

  logic               cfg_wr, in_acc, stopped, literal;
  logic [2:0]         bpp_eff, bip_inc;
  logic [CW-1:0]      cnt_eff, pd_inc, remaining, pd_run;
  logic               pix_end, excess, over, lit_fin, run_fin;
  logic [7:0]         ppl_dec, n_run;
  logic [10:0]        total_full;
  logic [tgarle_pkg::TOTAL_W-1:0] total;
  logic [31:0]        color_new;

  assign cfg_ready = 1'b1;
  assign in_tready = !fifo_stat.full;
  assign cfg_wr    = cfg_valid;
  assign in_acc    = in_tvalid && in_tready;
  assign stopped   = fin_r || err_r;
  assign literal   = !rle_r || (phase_r == tgarle_pkg::PH_RAW);

  // 0 acts as 1, 5..7 act as 4
  assign bpp_eff = (bpp_r == 3'd0) ? 3'd1 : ((bpp_r > 3'd4) ? 3'd4 : bpp_r);
  assign cnt_eff = (cnt_r > CW'(tgarle_pkg::MAX_PIXELS)) ? CW'(tgarle_pkg::MAX_PIXELS)
                                                         : cnt_r;

  assign bip_inc = {1'b0, bip_r} + 3'd1;
  assign pix_end = (bip_inc >= bpp_eff);
  assign excess  = (bip_r == 2'd0) && (pd_r >= cnt_eff);
  assign pd_inc  = pd_r + CW'(1);
  assign ppl_dec = (ppl_r != 8'd0) ? ppl_r - 8'd1 : 8'd0;
  assign lit_fin = (pd_inc >= cnt_eff) && (!rle_r || ppl_dec == 8'd0);

  // run expansion: clip to the pixels still allowed
  assign color_new  = color_r | ({24'd0, in_tdata} << {bip_r, 3'b000});
  assign remaining  = (pd_r < cnt_eff) ? cnt_eff - pd_r : '0;
  assign n_run      = ({13'd0, ppl_r} < remaining) ? ppl_r : remaining[7:0];
  assign over       = (ppl_r != n_run);
  assign total_full = {3'd0, n_run} * {8'd0, bpp_eff};
  assign total      = total_full[tgarle_pkg::TOTAL_W-1:0];
  assign pd_run     = pd_r + {13'd0, n_run};
  assign run_fin    = !over && (pd_run >= cnt_eff);

  always_comb begin
    phase_nxt = phase_r;
    if (cfg_wr && cfg_index == tgarle_pkg::CFG_COUNT) begin
      phase_nxt = tgarle_pkg::PH_HEADER;
    end else if (in_acc && !stopped && rle_r) begin
      case (phase_r)
        tgarle_pkg::PH_RAW: begin
          if (!excess && pix_end && ppl_dec == 8'd0) begin
            phase_nxt = tgarle_pkg::PH_HEADER;
          end
        end
        tgarle_pkg::PH_RUN: begin
          if (pix_end) begin
            phase_nxt = tgarle_pkg::PH_HEADER;
          end
        end
        default: begin
          phase_nxt = (in_tdata >= tgarle_pkg::RUN_HDR_MIN) ? tgarle_pkg::PH_RUN
                                                            : tgarle_pkg::PH_RAW;
        end
      endcase
    end
  end

  always_comb begin
    ppl_nxt   = ppl_r;
    bip_nxt   = bip_r;
    color_nxt = color_r;
    pd_nxt    = pd_r;
    fin_nxt   = fin_r;
    err_nxt   = err_r;
    bpp_nxt   = bpp_r;
    cnt_nxt   = cnt_r;
    rle_nxt   = rle_r;
    push      = 1'b0;
    push_cmd  = '0;
    if (cfg_wr) begin
      case (cfg_index)
        tgarle_pkg::CFG_BPP: bpp_nxt = cfg_data[2:0];
        tgarle_pkg::CFG_COUNT: begin
          cnt_nxt   = cfg_data;
          ppl_nxt   = 8'd0;
          bip_nxt   = 2'd0;
          color_nxt = '0;
          pd_nxt    = '0;
          err_nxt   = 1'b0;
          fin_nxt   = (cfg_data == '0);
        end
        tgarle_pkg::CFG_RLE: rle_nxt = cfg_data[0];
        default: ;
      endcase
    end else if (in_acc && !stopped) begin
      if (literal) begin
        push = 1'b1;
        if (excess) begin
          err_nxt         = 1'b1;
          push_cmd.status = 1'b1;
        end else begin
          push_cmd.one_byte = 1'b1;
          push_cmd.data     = {24'd0, in_tdata};
          if (pix_end) begin
            bip_nxt       = 2'd0;
            pd_nxt        = pd_inc;
            fin_nxt       = lit_fin;
            push_cmd.done = lit_fin;
            if (rle_r) begin
              ppl_nxt = ppl_dec;
            end
          end else begin
            bip_nxt = bip_inc[1:0];
          end
        end
      end else if (phase_r == tgarle_pkg::PH_RUN) begin
        color_nxt = color_new;
        if (!pix_end) begin
          bip_nxt = bip_inc[1:0];
        end else begin
          ppl_nxt         = 8'd0;
          bip_nxt         = 2'd0;
          pd_nxt          = pd_run;
          err_nxt         = over;
          fin_nxt         = run_fin;
          push            = 1'b1;
          push_cmd.is_run = (total != '0);
          push_cmd.data   = color_new;
          push_cmd.total  = total;
          push_cmd.bpp    = bpp_eff;
          push_cmd.status = over;
          push_cmd.done   = run_fin;
        end
      end else begin
        ppl_nxt   = (in_tdata >= tgarle_pkg::RUN_HDR_MIN) ? in_tdata - tgarle_pkg::RUN_HDR_BIAS
                                                          : in_tdata + 8'd1;
        bip_nxt   = 2'd0;
        color_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tgarle_pkg::PH_HEADER;
      ppl_r   <= 8'd0;
      bip_r   <= 2'd0;
      color_r <= '0;
      pd_r    <= '0;
      fin_r   <= 1'b0;
      err_r   <= 1'b0;
      bpp_r   <= 3'd3;
      cnt_r   <= CW'(1);
      rle_r   <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      ppl_r   <= ppl_nxt;
      bip_r   <= bip_nxt;
      color_r <= color_nxt;
      pd_r    <= pd_nxt;
      fin_r   <= fin_nxt;
      err_r   <= err_nxt;
      bpp_r   <= bpp_nxt;
      cnt_r   <= cnt_nxt;
      rle_r   <= rle_nxt;
    end
  end

  // an overrun never counts as completion
  a_fin_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(fin_r && err_r))
    else $error("finished and error set together");

endmodule

// File: rtl/core/tgarle_back.sv
// Back end: pops queue commands and emits result words through an output register.
// Runs expand at up to 8 bytes per cycle while out_tready allows. Depends on tgarle_pkg.

module tgarle_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tgarle_pkg::fifo_stat_t fifo_stat,
  input  tgarle_pkg::cmd_t       head,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [tgarle_pkg::OUT_TDATA_W-1:0] out_tdata,  // [63:0] out_bytes, [67:64] byte_count
  output logic                   out_tlast,              // last
  output logic [1:0]             out_tuser               // [0] status, [1] done_res
);

  localparam int unsigned TW = tgarle_pkg::TOTAL_W;

  // v mod m for v < 16 and m in 1..4
  function automatic logic [1:0] mod_bpp(input logic [3:0] v, input logic [2:0] m);
    logic [1:0] r;
    case (m)
      3'd2: r = {1'b0, v[0]};
      3'd4: r = v[1:0];
      3'd3: begin
        case (v)
          4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
          4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
          default:                              r = 2'd2;
        endcase
      end
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  logic             running_r, running_nxt;
  tgarle_pkg::cmd_t cur_r;
  logic [TW-1:0]    left_r, left_nxt;
  logic [1:0]       sel_r, sel_nxt;

  logic             oval_r, oval_nxt;
  logic [63:0]      obytes_r, obytes_nxt;
  logic [3:0]       ocnt_r, ocnt_nxt;
  logic             olast_r, olast_nxt;
  logic             ostat_r, ostat_nxt;
  logic             odone_r, odone_nxt;

  logic             load_ok, gen, take_head;
  logic [31:0]      src_color;
  logic [2:0]       src_bpp;
  logic [TW-1:0]    src_left, left_after;
  logic [1:0]       src_sel;
  logic             src_status, src_done, word_last;
  logic [3:0]       wcnt;
  logic [63:0]      word;
  logic [1:0]       idx;

  assign load_ok   = !oval_r || out_tready;
  assign take_head = !running_r && !fifo_stat.empty;
  assign gen       = load_ok && (running_r || !fifo_stat.empty);
  assign pop       = load_ok && take_head;

  always_comb begin
    if (running_r) begin
      src_color  = cur_r.data;
      src_bpp    = cur_r.bpp;
      src_left   = left_r;
      src_sel    = sel_r;
      src_status = cur_r.status;
      src_done   = cur_r.done;
    end else begin
      src_color  = head.data;
      src_bpp    = head.bpp;
      src_left   = head.total;
      src_sel    = 2'd0;
      src_status = head.status;
      src_done   = head.done;
    end
  end

  assign wcnt       = (src_left >= TW'(8)) ? 4'd8 : src_left[3:0];
  assign left_after = src_left - {{(TW-4){1'b0}}, wcnt};
  assign word_last  = (left_after == '0);

  always_comb begin
    word = '0;
    idx  = 2'd0;
    for (int c = 0; c < 8; c++) begin
      idx = mod_bpp({2'b00, src_sel} + 4'(c), src_bpp);
      if (4'(c) < wcnt) begin
        word[8*c +: 8] = src_color[{idx, 3'b000} +: 8];
      end
    end
  end

  always_comb begin
    running_nxt = running_r;
    left_nxt    = left_r;
    sel_nxt     = sel_r;
    oval_nxt    = oval_r && !out_tready;
    obytes_nxt  = obytes_r;
    ocnt_nxt    = ocnt_r;
    olast_nxt   = olast_r;
    ostat_nxt   = ostat_r;
    odone_nxt   = odone_r;
    if (gen) begin
      oval_nxt = 1'b1;
      if (take_head && !head.is_run) begin
        obytes_nxt = head.one_byte ? {56'd0, head.data[7:0]} : 64'd0;
        ocnt_nxt   = {3'd0, head.one_byte};
        olast_nxt  = 1'b1;
        ostat_nxt  = head.status;
        odone_nxt  = head.done;
      end else begin
        obytes_nxt  = word;
        ocnt_nxt    = wcnt;
        olast_nxt   = word_last;
        ostat_nxt   = word_last && src_status;
        odone_nxt   = word_last && src_done;
        running_nxt = !word_last;
        left_nxt    = left_after;
        sel_nxt     = mod_bpp({2'b00, src_sel} + wcnt, src_bpp);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      oval_r    <= 1'b0;
    end else begin
      running_r <= running_nxt;
      oval_r    <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r   <= left_nxt;
    sel_r    <= sel_nxt;
    obytes_r <= obytes_nxt;
    ocnt_r   <= ocnt_nxt;
    olast_r  <= olast_nxt;
    ostat_r  <= ostat_nxt;
    odone_r  <= odone_nxt;
    if (pop) begin
      cur_r <= head;
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = {4'd0, ocnt_r, obytes_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = {odone_r, ostat_r};

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (ocnt_r <= 4'd8))
    else $error("byte count above eight");

  // error and completion flags only ride on the closing word of a command
  a_flags_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (ostat_r || odone_r)) |-> olast_r)
    else $error("status or done on a non-final word");

endmodule

// File: rtl/core/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder.
// Depends on tgarle_pkg, tgarle_front, tgarle_cmd_fifo and tgarle_back.
//
// Usage:
//   in_*  : one image-data byte per transaction in in_tdata[7:0].
//   out_* : decoded bytes packed little-endian, out_tdata[63:0] bytes,
//           out_tdata[67:64] valid byte count; out_tlast marks the final
//           word caused by one input byte; out_tuser[0] overrun error,
//           out_tuser[1] all configured pixels emitted.
//   cfg_* : register write, cfg_index 0 bytes_per_pixel, 1 pixel_count
//           (restarts decoding), 2 rle_mode; always ready. Write only idle.
// Timing: results pass the command queue, then the output register. While
//   out_tready is high, literal bytes flow at one per cycle and a run packet
//   of n pixels expands into ceil(n*bpp/8) words, one per cycle from the back
//   end's word builder. A four-entry command queue decouples the two halves,
//   so input is taken while words wait; in_tready drops only with queue full.
// Reset: rst_n (synchronous, low) clears the queue and output register and
//   sets bytes_per_pixel 3, pixel_count 1, rle_mode 1.
// Back-pressure: out_tready low holds the current word; the queue fills and
//   then stalls the input side. Bytes after completion or error are taken
//   and dropped until pixel_count is rewritten.

module tga_rle_pixel_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [tgarle_pkg::OUT_TDATA_W-1:0] out_tdata,  // [63:0] out_bytes, [67:64] byte_count
  output logic        out_tlast,   // last
  output logic [1:0]  out_tuser,   // [0] status, [1] done_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data
);

  tgarle_pkg::fifo_stat_t fifo_stat;
  tgarle_pkg::cmd_t       push_cmd, head;
  logic                   push, pop;

  tgarle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  tgarle_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (fifo_stat)
  );

  tgarle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_stat  (fifo_stat),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// File: test/tb_top.sv
// Self-checking bench for tga_rle_pixel_decoder: drives image-data bytes, predicts
// the packed pixel words with a behavioral decoder and compares every result.
// Depends on tgarle_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] CFG_UNUSED = 2'd3;   // no register behind this index

  // per-phase settings of the random part
  localparam logic [2:0] BPP_PLAN [0:7] = '{3'd1, 3'd3, 3'd4, 3'd2, 3'd7, 3'd3, 3'd0, 3'd4};

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
    logic        status;
    logic        done;
  } word_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [tgarle_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [20:0] cfg_data = 21'd0;

  logic [7:0] pending_bytes [$];
  word_t      expected_words [$];
  word_t      want_word;
  int         mismatches = 0;
  bit         steady = 1'b0;    // no idling on either side while set

  // behavioral decoder state
  logic [2:0]          reg_bpp;
  logic [20:0]         reg_count;
  logic                reg_rle;
  tgarle_pkg::phase_t  dec_phase;
  int unsigned         pkt_left;
  int unsigned         pix_byte;
  int unsigned         pixels_out;
  logic [31:0]         run_rgba;
  bit                  dec_done;
  bit                  dec_err;

  tga_rle_pixel_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned pixel_bytes();
    if (reg_bpp == 3'd0) return 1;
    if (reg_bpp > 3'd4) return 4;
    return reg_bpp;
  endfunction

  function automatic int unsigned pixel_limit();
    return (reg_count > tgarle_pkg::MAX_PIXELS) ? tgarle_pkg::MAX_PIXELS : reg_count;
  endfunction

  function automatic void restart_decode();
    dec_phase  = tgarle_pkg::PH_HEADER;
    pkt_left   = 0;
    pix_byte   = 0;
    run_rgba   = 32'd0;
    pixels_out = 0;
    dec_err    = 1'b0;
    dec_done   = (pixel_limit() == 0);
  endfunction

  function automatic void push_word(input logic [63:0] d, input int unsigned n,
                                    input bit l, input bit s, input bit dn);
    expected_words.push_back('{d, 4'(n), l, s, dn});
  endfunction

  // one literal byte, raw packet or pass-through
  function automatic void take_literal(input logic [7:0] b, input bit rle);
    int unsigned bpp;
    int unsigned lim;
    bpp = pixel_bytes();
    lim = pixel_limit();
    if (pix_byte == 0 && pixels_out >= lim) begin
      dec_err = 1'b1;
      push_word(64'd0, 0, 1'b1, 1'b1, 1'b0);
      return;
    end
    pix_byte++;
    if (pix_byte >= bpp) begin
      pix_byte = 0;
      pixels_out++;
      if (rle) begin
        if (pkt_left > 0) pkt_left--;
        if (pkt_left == 0) dec_phase = tgarle_pkg::PH_HEADER;
      end
      // count reached inside a raw packet with pixels left: not done yet
      if (pixels_out >= lim && (!rle || pkt_left == 0)) dec_done = 1'b1;
    end
    push_word(64'(b), 1, 1'b1, 1'b0, dec_done);
  endfunction

  function automatic void expand_run_words();
    int unsigned bpp, lim, remaining, n, total, pos, sel, c;
    bit over;
    logic [63:0] word;
    bpp = pixel_bytes();
    lim = pixel_limit();
    remaining = (pixels_out < lim) ? lim - pixels_out : 0;
    n = (pkt_left < remaining) ? pkt_left : remaining;
    over = pkt_left > n;
    total = n * bpp;
    pos = 0;
    sel = 0;
    pixels_out += n;
    pkt_left = 0;
    dec_phase = tgarle_pkg::PH_HEADER;
    pix_byte = 0;
    if (over) dec_err = 1'b1;
    else if (pixels_out >= lim) dec_done = 1'b1;
    if (total == 0) begin
      push_word(64'd0, 0, 1'b1, over, dec_done);
      return;
    end
    while (pos < total) begin
      word = 64'd0;
      c = 0;
      while (c < 8 && pos < total) begin
        word[8*c +: 8] = run_rgba[8*sel +: 8];
        c++;
        pos++;
        sel++;
        if (sel >= bpp) sel = 0;
      end
      if (pos >= total) push_word(word, c, 1'b1, over, dec_done);
      else push_word(word, c, 1'b0, 1'b0, 1'b0);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    if (dec_done || dec_err) return;
    if (!reg_rle) begin
      take_literal(b, 1'b0);
      return;
    end
    case (dec_phase)
      tgarle_pkg::PH_RAW: take_literal(b, 1'b1);
      tgarle_pkg::PH_RUN: begin
        run_rgba |= 32'(b) << (8 * (pix_byte & 3));
        pix_byte++;
        if (pix_byte >= pixel_bytes()) expand_run_words();
      end
      default: begin
        if (b < tgarle_pkg::RUN_HDR_MIN) begin
          dec_phase = tgarle_pkg::PH_RAW;
          pkt_left  = b + 1;
        end else begin
          dec_phase = tgarle_pkg::PH_RUN;
          pkt_left  = b - tgarle_pkg::RUN_HDR_BIAS;
        end
        pix_byte = 0;
        run_rgba = 32'd0;
      end
    endcase
  endfunction

  function automatic void check_field(input string fname, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      mismatches++;
    end
  endfunction

  // input driver: predicts each accepted byte, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) decode_byte(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_bytes.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $error("result transaction with nothing expected: data %0h", out_tdata[63:0]);
        mismatches++;
      end else begin
        want_word = expected_words.pop_front();
        check_field("out_bytes", want_word.data, out_tdata[63:0]);
        check_field("byte_count", 64'(want_word.nbytes), 64'(out_tdata[67:64]));
        check_field("last", 64'(want_word.last), 64'(out_tlast));
        check_field("status", 64'(want_word.status), 64'(out_tuser[0]));
        check_field("done_res", 64'(want_word.done), 64'(out_tuser[1]));
      end
    end
    out_tready <= steady || ($urandom_range(99) >= 27);
  end

  // returns on a rising edge once every byte is in and every word is out
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_tvalid || expected_words.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [20:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    case (idx)
      tgarle_pkg::CFG_BPP:   reg_bpp = val[2:0];
      tgarle_pkg::CFG_COUNT: begin
        reg_count = val;
        restart_decode();
      end
      tgarle_pkg::CFG_RLE:   reg_rle = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // with rle, mostly well-formed packets with random content, some stray bytes; else random bytes
  task automatic queue_stream(input int unsigned n, input int unsigned bpp, input bit rle);
    int unsigned made, hdr, k, r;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99);
      if (!rle || r < 8) begin
        pending_bytes.push_back(8'($urandom));
        made++;
      end else if (r < 50) begin
        hdr = (r < 25) ? $urandom_range(128, 135) : $urandom_range(128, 255);
        pending_bytes.push_back(8'(hdr));
        for (k = 0; k < bpp; k++) pending_bytes.push_back(8'($urandom));
        made += 1 + bpp;
      end else begin
        hdr = ($urandom_range(23) == 0) ? $urandom_range(16, 128 / bpp - 1)
                                        : $urandom_range(0, 5);
        pending_bytes.push_back(8'(hdr));
        for (k = 0; k < (hdr + 1) * bpp; k++) pending_bytes.push_back(8'($urandom));
        made += 1 + (hdr + 1) * bpp;
      end
    end
  endtask

  initial begin
    int unsigned eb, n;
    logic [20:0] cnt;
    bit small_set;
    reg_bpp   = 3'd3;
    reg_count = 21'd1;
    reg_rle   = 1'b1;
    restart_decode();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one-pixel run completes the image
    pending_bytes = {8'h80, 8'hFF, 8'h00, 8'hAA};
    wait_idle();

    // raw pixel, then a 128-pixel run that overruns a three-pixel image
    write_reg(tgarle_pkg::CFG_BPP, 21'd4);
    write_reg(tgarle_pkg::CFG_COUNT, 21'd3);
    pending_bytes = {8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04};
    wait_idle();

    // count reached inside a raw packet; its next pixel is an overrun
    write_reg(tgarle_pkg::CFG_BPP, 21'd1);
    write_reg(tgarle_pkg::CFG_COUNT, 21'd1);
    pending_bytes = {8'h01, 8'h11, 8'h22};
    wait_idle();

    // pass-through with bpp 0 (acts as 1); the byte after completion is dropped
    write_reg(tgarle_pkg::CFG_RLE, 21'd0);
    write_reg(tgarle_pkg::CFG_BPP, 21'd0);
    write_reg(tgarle_pkg::CFG_COUNT, 21'd2);
    pending_bytes = {8'h7F, 8'h80, 8'h33};
    wait_idle();

    // zero pixels: finished at once
    write_reg(tgarle_pkg::CFG_COUNT, 21'd0);
    pending_bytes = {8'h44};
    wait_idle();

    // bpp and mode changed in the middle of a pixel, plus a write to no register
    write_reg(tgarle_pkg::CFG_RLE, 21'd1);
    write_reg(tgarle_pkg::CFG_BPP, 21'd4);
    write_reg(tgarle_pkg::CFG_COUNT, 21'h1FFFFF);
    pending_bytes = {8'h02, 8'hA1, 8'hA2};
    wait_idle();
    write_reg(tgarle_pkg::CFG_BPP, 21'd2);
    write_reg(CFG_UNUSED, 21'h15AA5);
    pending_bytes = {8'hA3};
    wait_idle();
    write_reg(tgarle_pkg::CFG_RLE, 21'd0);
    pending_bytes = {8'hC1};
    wait_idle();
    write_reg(tgarle_pkg::CFG_RLE, 21'd1);
    pending_bytes = {8'hB1, 8'hB2, 8'h81, 8'hD1, 8'hD2};
    wait_idle();

    // random part
    for (int i = 0; i < 8; i++) begin
      small_set = (i == 3 || i == 6);
      if (i == 0) cnt = 21'h1FFFFF;
      else if (i == 1) cnt = 21'(tgarle_pkg::MAX_PIXELS);
      else if (small_set) cnt = 21'($urandom_range(3, 20));
      else cnt = 21'($urandom_range(700, 21'h1FFFFF));
      eb = (BPP_PLAN[i] == 3'd0) ? 1 : ((BPP_PLAN[i] > 3'd4) ? 4 : BPP_PLAN[i]);
      n = small_set ? 16 : 40;
      steady = (i == 2);
      write_reg(tgarle_pkg::CFG_BPP, (21'($urandom) & ~21'h7) | 21'(BPP_PLAN[i]));
      write_reg(tgarle_pkg::CFG_RLE, (21'($urandom) & ~21'h1) | 21'(i != 5));
      write_reg(tgarle_pkg::CFG_COUNT, cnt);
      queue_stream(n, eb, i != 5);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $error("timeout: %0d words still expected", expected_words.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
